// ===== design/assert_macros.svh =====
// Assertion macros for the decimal text converter RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is asserted
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ===== design/sitda_pkg.sv =====
// Shared types and constants for the decimal text converter.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package sitda_pkg;

    // ASCII codes as carried on the six-bit character field
    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [5:0] ASCII_MINUS = 6'd45;
    localparam int         CHAR_W      = 6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take a new value, form the magnitude
        logic shift;       // one double-dabble step
        logic skip;        // drop a leading zero digit
        logic emit_sign;   // put '-' in the output register
        logic emit_digit;  // put the top digit in the output register
    } sitda_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic negative;    // value taken was negative
        logic last_shift;  // the current shift is the final one
        logic top_zero;    // top remaining digit is zero
        logic one_left;    // only one digit remains
        logic out_free;    // output register can take a character this cycle
    } sitda_stat_t;

endpackage

`default_nettype wire

// ===== design/sitda_ctrl.sv =====
// Controller state machine for the decimal text converter.
// Depends on sitda_pkg; drives commands to sitda_dp and reads its status.
`default_nettype none

module sitda_ctrl
    import sitda_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire sitda_stat_t stat,
    output sitda_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Sequence load, conversion, zero suppression and character emission
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                if (stat.last_shift) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (stat.top_zero && !stat.one_left) begin
                    cmd.skip = 1'b1;
                end else if (stat.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (stat.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (stat.one_left) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/sitda_dp.sv =====
// Datapath for the decimal text converter: magnitude, double-dabble BCD
// register, digit counters and the output register. Depends on sitda_pkg.
`default_nettype none
`include "assert_macros.svh"

module sitda_dp
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire sitda_cmd_t            cmd,
    output sitda_stat_t                stat,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [CHAR_W-1:0]          out_char,
    output logic                       out_last
);

    // Digits of 2^VALUE_BITS bound the magnitude's digit count
    localparam int NDIG  = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int SH_W  = $clog2(VALUE_BITS + 1);
    localparam int DG_W  = $clog2(NDIG + 1);

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    logic [SH_W-1:0]       sh_cnt_reg, sh_cnt_next;
    logic [DG_W-1:0]       dig_cnt_reg, dig_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;
    logic                  out_free;
    logic                  char_ok;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || out_ready;

    // Next values of the conversion registers
    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        sh_cnt_next  = sh_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        if (cmd.load) begin
            neg_next     = in_value[VALUE_BITS-1];
            bin_next     = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
            bcd_next     = '0;
            sh_cnt_next  = SH_W'(VALUE_BITS);
            dig_cnt_next = DG_W'(NDIG);
        end else if (cmd.shift) begin
            {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
            sh_cnt_next          = sh_cnt_reg - SH_W'(1);
        end else if (cmd.skip || cmd.emit_digit) begin
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - DG_W'(1);
        end
    end

    // Load the output register, or drop its character once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit_sign) begin
            out_valid_next = 1'b1;
            out_char_next  = ASCII_MINUS;
            out_last_next  = 1'b0;
        end else if (cmd.emit_digit) begin
            out_valid_next = 1'b1;
            out_char_next  = ASCII_ZERO + {2'b00, top_digit};
            out_last_next  = (dig_cnt_reg == DG_W'(1));
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sh_cnt_reg    <= '0;
            dig_cnt_reg   <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            sh_cnt_reg    <= sh_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign stat.negative   = neg_reg;
    assign stat.last_shift = (sh_cnt_reg == SH_W'(1));
    assign stat.top_zero   = (top_digit == 4'd0);
    assign stat.one_left   = (dig_cnt_reg == DG_W'(1));
    assign stat.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    // Character is either the minus sign or a decimal digit
    assign char_ok = (out_char_reg == ASCII_MINUS) ||
                     ((out_char_reg >= ASCII_ZERO) && (out_char_reg <= ASCII_ZERO + 6'd9));

    `ASSERT_CLK(a_char_range, aclk, aresetn, out_valid_reg |-> char_ok, "character outside '-' and digits")
    `ASSERT_NEVER(a_emit_no_digits, aclk, aresetn, (cmd.emit_digit || cmd.skip) && (dig_cnt_reg == '0), "digit taken with none remaining")
    `ASSERT_CLK(a_bcd_digit, aclk, aresetn, (cmd.emit_digit || cmd.skip) |-> (top_digit <= 4'd9), "BCD digit above nine")

endmodule

`default_nettype wire

// ===== design/signed_int_to_decimal_ascii.sv =====
// Converts one signed integer per request into its decimal ASCII text.
// Usage:
//   Slave channel s_tvalid/s_tready/s_tdata takes one two's-complement value
//   per request in the low VALUE_BITS bits of s_tdata.
//   Master channel m_tvalid/m_tready/m_tdata/m_tlast returns the text one
//   character per request, most significant first: '-' for a negative value,
//   then the digits without leading zeros; zero gives a single '0'. m_tlast
//   marks the final character of each value.
// Sequence:
//   After acceptance the value is shifted through a double-dabble BCD
//   register, one bit per cycle, then leading zero digits are dropped one
//   per cycle and a further step picks sign or digit, then one character
//   leaves per cycle while the receiver takes them. NDIG is the digit
//   capacity of the BCD register (10 at 32 bits).
// Reset and stalls:
//   aresetn (synchronous, active low) returns the block to idle and empties
//   the output register. If the receiver holds m_tready low, the character
//   waits in the output register and emission pauses; the next value is
//   accepted while the final character of the previous one still waits.
`default_nettype none

module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,   // value
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // char_code
    output logic                                   m_tlast
);

    sitda_cmd_t        cmd;
    sitda_stat_t       stat;
    logic [CHAR_W-1:0] out_char;

    sitda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sitda_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_value  (s_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    // Pad the character code to a whole byte
    assign m_tdata = {{(8-CHAR_W){1'b0}}, out_char};

endmodule

`default_nettype wire

// ===== verif/decimal_text_checker.sv =====
// Checker for the signed integer to decimal ASCII converter: predicts the text
// of every accepted request and compares each character leaving the block.
// Depends on sitda_pkg for the ASCII codes and the character width.
module decimal_text_checker
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int IN_W       = ((VALUE_BITS + 7) / 8) * 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    input  wire logic            s_tready,
    input  wire logic [IN_W-1:0] s_tdata,    // value
    input  wire logic            m_tvalid,
    input  wire logic            m_tready,
    input  wire logic [7:0]      m_tdata,    // char_code
    input  wire logic            m_tlast,
    output int                   mismatches,
    output int                   pending_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] RADIX = 4'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } glyph_t;

    // characters still owed by the block, oldest first
    glyph_t owed_glyphs[$];

    // Append the decimal text of one value: sign, then digits without leading zeros
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS:0] magnitude;
        byte unsigned        digits[$];
        glyph_t              g;
        // widen before negating so the most negative value keeps its magnitude
        if (value[VALUE_BITS-1]) begin
            magnitude = {1'b0, ~value} + 1'b1;
        end else begin
            magnitude = {1'b0, value};
        end
        do begin
            digits.push_front(byte'(magnitude % RADIX));
            magnitude = magnitude / RADIX;
        end while (magnitude != 0);
        if (value[VALUE_BITS-1]) begin
            g.code = ASCII_MINUS;
            g.last = 1'b0;
            owed_glyphs.push_back(g);
        end
        foreach (digits[i]) begin
            g.code = ASCII_ZERO + digits[i][CHAR_W-1:0];
            g.last = (i == digits.size() - 1);
            owed_glyphs.push_back(g);
        end
    endfunction

    // Predict on each accepted request, compare on each accepted character
    always @(posedge aclk) begin : watch
        glyph_t got;
        glyph_t want;
        if (!aresetn) begin
            owed_glyphs.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_text(s_tdata[VALUE_BITS-1:0]);
            end
            if (m_tvalid && m_tready) begin
                got.code = m_tdata[CHAR_W-1:0];
                got.last = m_tlast;
                if (owed_glyphs.size() == 0) begin
                    $display("%0t: unexpected character, expected none, actual code %0d last %0b",
                             $time, got.code, got.last);
                    mismatches <= mismatches + 1;
                end else begin
                    want = owed_glyphs.pop_front();
                    if (got !== want) begin
                        $display("%0t: character mismatch, expected code %0d last %0b, actual code %0d last %0b",
                                 $time, want.code, want.last, got.code, got.last);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        pending_chars <= owed_glyphs.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the converter test: clock, reset, request stimulus and receiver stalls.
// Depends on signed_int_to_decimal_ascii and decimal_text_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS    = 32;
    localparam int RANDOM_ITEMS  = 330;
    localparam int SETTLE_CYCLES = 60;
    localparam int LIMIT_CYCLES  = 500000;

    typedef enum int { RX_FREE, RX_RANDOM, RX_THROTTLE } rx_mode_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // char_code
    logic        m_tlast;

    int          mismatches;
    int          pending_chars;
    int          cycle_count = 0;
    int          burst_left  = 0;
    rx_mode_t    rx_mode     = RX_FREE;
    int          rx_mode_left = 0;
    int          rx_phase    = 0;

    // edge cases first: zero, single digits, digit-count boundaries, extremes
    int corner_values[21] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -12345,
                              999999999, -999999999, 1000000000, -1000000000,
                              2147483647, -2147483647, 32'h80000000, 32'h55555555,
                              32'hAAAAAAAA};

    signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    decimal_text_checker #(.VALUE_BITS(VALUE_BITS)) text_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending_chars (pending_chars)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: switch between free running, coin-flip and throttled stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= rx_mode_t'($urandom_range(RX_FREE, RX_THROTTLE));
                rx_mode_left <= $urandom_range(50, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            rx_phase <= (rx_phase == 9) ? 0 : rx_phase + 1;
            case (rx_mode)
                RX_FREE:     m_tready <= 1'b1;
                RX_RANDOM:   m_tready <= $urandom_range(0, 1);
                RX_THROTTLE: m_tready <= (rx_phase >= 7);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    // Pick a value, biased towards digit-count boundaries and small magnitudes
    function automatic logic [31:0] pick_value();
        int unsigned pow_ten;
        int          k;
        int          v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 999);
            6, 7: begin
                pow_ten = 1;
                k = $urandom_range(0, 9);
                repeat (k) pow_ten = pow_ten * 10;
                v = int'(pow_ten) + $urandom_range(0, 2) - 1;
            end
            8:       v = $urandom >> $urandom_range(0, 31);
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFFFFFF;
                    1:       v = 32'h80000000;
                    2:       v = 32'h80000001;
                    3:       v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    // Offer one request; open a new burst with a random gap when the old one runs out
    task automatic send_value(input logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold off until every owed character has left the block
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_chars != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int idx;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_values[i]) begin
            send_value(corner_values[i]);
        end
        drain_pause();

        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            if (idx == RANDOM_ITEMS / 2) begin
                drain_pause();
            end
            send_value(pick_value());
        end

        // drop valid, let the last text drain, then give the verdict
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_chars != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_chars == 0) begin
            $display("end of test: clean");
            $finish;
        end else begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
